FILE: rtl/core/ted_pkg.sv
`timescale 1ns / 1ps
// ted_pkg: types, byte constants and byte class helpers for the text encoding detector
// depends on nothing; imported by text_encoding_detector and its bench

package ted_pkg;

    // verdict codes
    typedef enum logic [1:0] {
        VERDICT_UTF8   = 2'd0,
        VERDICT_EUC    = 2'd1,
        VERDICT_SJIS   = 2'd2,
        VERDICT_BINARY = 2'd3
    } t_verdict;

    // position inside a multi-byte group
    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // kind of group closed by the current byte
    typedef enum logic [2:0] {
        GRP_NONE,
        GRP_UTF8,
        GRP_EUC,
        GRP_SJIS,
        GRP_UNK
    } t_grp;

    localparam logic [7:0] B_NUL       = 8'h00;
    localparam logic [7:0] B_TAB       = 8'h09;
    localparam logic [7:0] B_LF        = 8'h0A;
    localparam logic [7:0] B_CR        = 8'h0D;
    localparam logic [7:0] B_SPACE     = 8'h20;
    localparam logic [7:0] B_TILDE     = 8'h7E;
    localparam logic [7:0] B_CONT_LO   = 8'h80;
    localparam logic [7:0] B_CONT_HI   = 8'hBF;
    localparam logic [7:0] B_U2_LO     = 8'hC2;
    localparam logic [7:0] B_U2_HI     = 8'hDF;
    localparam logic [7:0] B_U3_E0     = 8'hE0;
    localparam logic [7:0] B_U3_E0_LO  = 8'hA0;
    localparam logic [7:0] B_U3_LO     = 8'hE1;
    localparam logic [7:0] B_U3_HI     = 8'hEC;
    localparam logic [7:0] B_U3_ED     = 8'hED;
    localparam logic [7:0] B_U3_ED_HI  = 8'h9F;
    localparam logic [7:0] B_U3_EE     = 8'hEE;
    localparam logic [7:0] B_U3_EF     = 8'hEF;
    localparam logic [7:0] B_EUC_SS2   = 8'h8E;
    localparam logic [7:0] B_EUC_LO    = 8'hA1;
    localparam logic [7:0] B_EUC_HI    = 8'hFE;
    localparam logic [7:0] B_KANA_HI   = 8'hDF;
    localparam logic [7:0] B_SJ1_LO    = 8'h81;
    localparam logic [7:0] B_SJ1_HI    = 8'h9F;
    localparam logic [7:0] B_SJ1B_HI   = 8'hEF;
    localparam logic [7:0] B_SJ2_LO    = 8'h40;
    localparam logic [7:0] B_SJ2_HI    = 8'hFC;

    localparam int unsigned UNK_SCALE   = 100;
    localparam int unsigned COUNT_SCALE = 11;

    function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic is_ascii(input logic [7:0] b);
        return (b == B_TAB) || (b == B_LF) || (b == B_CR) || in_rng(b, B_SPACE, B_TILDE);
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return in_rng(b, B_CONT_LO, B_CONT_HI);
    endfunction

    function automatic logic utf8_three(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if (is_cont(c)) begin
            if (a == B_U3_E0)
                ok = in_rng(b, B_U3_E0_LO, B_CONT_HI);
            else if (in_rng(a, B_U3_LO, B_U3_HI) || (a == B_U3_EE) || (a == B_U3_EF))
                ok = is_cont(b);
            else if (a == B_U3_ED)
                ok = in_rng(b, B_CONT_LO, B_U3_ED_HI);
        end
        return ok;
    endfunction

    // lone lead: half-width kana or unknown
    function automatic t_grp single_grp(input logic [7:0] a);
        return in_rng(a, B_EUC_LO, B_KANA_HI) ? GRP_SJIS : GRP_UNK;
    endfunction

    function automatic t_grp pair_grp(input logic [7:0] a, input logic [7:0] b);
        t_grp g;
        if ((a == B_EUC_SS2) && in_rng(b, B_EUC_LO, B_KANA_HI))
            g = GRP_EUC;
        else if (in_rng(a, B_EUC_LO, B_EUC_HI) && in_rng(b, B_EUC_LO, B_EUC_HI))
            g = GRP_EUC;
        else if ((in_rng(a, B_SJ1_LO, B_SJ1_HI) || in_rng(a, B_U3_E0, B_SJ1B_HI)) &&
                 (in_rng(b, B_SJ2_LO, B_TILDE) || in_rng(b, B_CONT_LO, B_SJ2_HI)))
            g = GRP_SJIS;
        else
            g = single_grp(a);
        return g;
    endfunction

endpackage

FILE: rtl/core/text_encoding_detector.sv
`timescale 1ns / 1ps
// text_encoding_detector: classifies a file head as UTF-8, EUC-JP, Shift-JIS or binary
// depends on ted_pkg for verdict codes, group kinds and byte class helpers
//
// the byte that ends the file is accepted into the input register, and its verdict is
//   written into the result register when that byte is processed, where it waits to be taken
// throughput: one byte per cycle; the input register drains whenever the result
//   register is free or being taken, so the block only stalls on output backpressure
// reset: synchronous active low, clears the force bit, all group counters and the
//   group phase; the block starts expecting a lead byte of a new file
module text_encoding_detector
    import ted_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte requests
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    // verdict requests
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_verdict,
    output logic [9:0] o_bytes_examined,
    // configuration write requests
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_force_utf8
);

    // counters must hold the window length itself
    localparam int unsigned CW = $clog2(WINDOW_BYTES + 1);
    // width of the scaled counts in the binary test
    localparam int unsigned MW = CW + 7;
    localparam logic [CW-1:0] WINDOW_LIMIT = CW'(WINDOW_BYTES);

    // input register
    logic          r_in_valid;
    logic [7:0]    r_byte;
    logic          r_last;

    // per-file state
    t_phase        r_phase, n_phase;
    logic [7:0]    r_lead, n_lead;
    logic [7:0]    r_second, n_second;
    logic [CW-1:0] r_utf, n_utf;
    logic [CW-1:0] r_euc, n_euc;
    logic [CW-1:0] r_sjis, n_sjis;
    logic [CW-1:0] r_unk, n_unk;
    logic [CW-1:0] r_count, n_count;
    logic          r_given, n_given;
    logic          r_force;

    // result register
    logic          r_out_valid, n_out_valid;
    t_verdict      r_verdict, n_verdict;
    logic [9:0]    r_bytes, n_bytes;

    logic          w_proc;
    logic [CW-1:0] w_cnt_inc;
    logic          w_end;
    logic          w_nul_lead;
    t_grp          w_grp;
    logic [MW-1:0] w_unk_scaled;
    logic [MW-1:0] w_cnt_scaled;
    t_verdict      w_final;

    // the byte in the input register is consumed when the result register has room
    assign w_proc      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_proc;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_bytes_examined = r_bytes;

    // the file ends on a last flag or once the window is full
    assign w_cnt_inc  = r_count + CW'(1);
    assign w_end      = r_last || (w_cnt_inc >= WINDOW_LIMIT);
    assign w_nul_lead = (r_phase == PH_LEAD) && (r_byte == B_NUL);

    // group decoder: which group, if any, the current byte closes
    always_comb begin
        w_grp = GRP_NONE;
        unique case (r_phase)
            PH_LEAD: begin
                if (!w_nul_lead && !is_ascii(r_byte) && w_end)
                    w_grp = single_grp(r_byte);
            end
            PH_SECOND: begin
                if (in_rng(r_lead, B_U2_LO, B_U2_HI) && is_cont(r_byte))
                    w_grp = GRP_UTF8;
                else if (w_end)
                    w_grp = single_grp(r_lead);
            end
            default: begin
                // third byte; the unused phase code behaves the same way
                if (utf8_three(r_lead, r_second, r_byte))
                    w_grp = GRP_UTF8;
                else if (w_end)
                    w_grp = single_grp(r_lead);
                else
                    w_grp = pair_grp(r_lead, r_second);
            end
        endcase
    end

    // group phase next state
    always_comb begin
        n_phase  = r_phase;
        n_lead   = r_lead;
        n_second = r_second;
        unique case (r_phase)
            PH_LEAD: begin
                if (!w_nul_lead && !is_ascii(r_byte) && !w_end) begin
                    n_phase = PH_SECOND;
                    n_lead  = r_byte;
                end
            end
            PH_SECOND: begin
                if (w_grp != GRP_NONE) begin
                    n_phase = PH_LEAD;
                end else begin
                    n_phase  = PH_THIRD;
                    n_second = r_byte;
                end
            end
            default: begin
                n_phase = PH_LEAD;
            end
        endcase
    end

    // binary when unknown*100 >= 11*count, else the largest count with
    // ties going to utf-8 and then euc
    assign w_unk_scaled = MW'(n_unk) * MW'(UNK_SCALE);
    assign w_cnt_scaled = MW'(w_cnt_inc) * MW'(COUNT_SCALE);

    always_comb begin
        if (w_unk_scaled >= w_cnt_scaled)
            w_final = VERDICT_BINARY;
        else if ((n_utf >= n_euc) && (n_utf >= n_sjis))
            w_final = VERDICT_UTF8;
        else if (n_euc >= n_sjis)
            w_final = VERDICT_EUC;
        else
            w_final = VERDICT_SJIS;
    end

    // counters (the next-count values also feed the verdict above)
    always_comb begin
        n_utf  = r_utf  + CW'(w_grp == GRP_UTF8);
        n_euc  = r_euc  + CW'(w_grp == GRP_EUC);
        n_sjis = r_sjis + CW'(w_grp == GRP_SJIS);
        n_unk  = r_unk  + CW'(w_grp == GRP_UNK);
    end

    // result register next value
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_verdict   = r_verdict;
        n_bytes     = r_bytes;
        n_given     = r_given;
        if (w_proc && !r_given) begin
            if (r_force) begin
                n_out_valid = 1'b1;
                n_verdict   = VERDICT_UTF8;
            end else if (w_nul_lead) begin
                n_out_valid = 1'b1;
                n_verdict   = VERDICT_BINARY;
            end else if (w_end) begin
                n_out_valid = 1'b1;
                n_verdict   = w_final;
            end
            n_bytes = 10'(w_cnt_inc);
            if (n_out_valid && !r_last)
                n_given = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_force     <= 1'b0;
            r_phase     <= PH_LEAD;
            r_lead      <= '0;
            r_second    <= '0;
            r_utf       <= '0;
            r_euc       <= '0;
            r_sjis      <= '0;
            r_unk       <= '0;
            r_count     <= '0;
            r_given     <= 1'b0;
        end else begin
            if (i_cfg_valid)
                r_force <= i_force_utf8;

            if (o_in_ready)
                r_in_valid <= i_in_valid;

            r_out_valid <= n_out_valid;

            if (w_proc) begin
                if (r_given) begin
                    // bytes after the verdict are dropped until the file ends
                    if (r_last) begin
                        r_phase  <= PH_LEAD;
                        r_lead   <= '0;
                        r_second <= '0;
                        r_utf    <= '0;
                        r_euc    <= '0;
                        r_sjis   <= '0;
                        r_unk    <= '0;
                        r_count  <= '0;
                        r_given  <= 1'b0;
                    end
                end else if (n_out_valid && r_last) begin
                    // verdict on the final byte: rearm at once
                    r_phase  <= PH_LEAD;
                    r_lead   <= '0;
                    r_second <= '0;
                    r_utf    <= '0;
                    r_euc    <= '0;
                    r_sjis   <= '0;
                    r_unk    <= '0;
                    r_count  <= '0;
                    r_given  <= 1'b0;
                end else begin
                    r_count <= w_cnt_inc;
                    r_given <= n_given;
                    if (!r_force) begin
                        r_phase  <= n_phase;
                        r_lead   <= n_lead;
                        r_second <= n_second;
                        r_utf    <= n_utf;
                        r_euc    <= n_euc;
                        r_sjis   <= n_sjis;
                        r_unk    <= n_unk;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        r_verdict <= n_verdict;
        r_bytes   <= n_bytes;
    end

endmodule

FILE: sim/text_encoding_detector_tb.sv
`timescale 1ns / 1ps
// text_encoding_detector_tb: self-checking bench for the text encoding detector
// depends on ted_pkg and text_encoding_detector; scripted files first, then random
// files under several idle patterns, each verdict checked against a bench-side model or a typed script verdict

module text_encoding_detector_tb;
    import ted_pkg::*;

    localparam int unsigned WINDOW    = 512;
    localparam int unsigned LAT_GAP   = 8;       // quiet cycles before a config write
    localparam int unsigned HOLD_LEN  = 300;     // long receiver hold-off
    localparam int unsigned LIMIT     = 200000;  // watchdog, in clock cycles

    // one expected verdict request
    typedef struct packed {
        t_verdict   verdict;
        logic [9:0] examined;
    } t_verdict_rec;

    // scripted rows: a byte request or a write of the force bit
    typedef enum logic {ROW_BYTE, ROW_FORCE} t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic [7:0]   data;      // byte, or force value in bit 0
        logic         last;
        logic         typed;     // verdict written into the row
        t_verdict_rec rec;
    } t_row;

    // character shapes used to build random files
    typedef enum int {CH_ASCII, CH_U2, CH_U3, CH_EUC, CH_SS2, CH_SJIS, CH_KANA, CH_RAW} t_ch_kind;
    typedef enum int {FL_UTF8, FL_EUC, FL_SJIS, FL_MIXED, FL_NOISE} t_flavor;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [1:0] o_verdict;
    logic [9:0] o_bytes_examined;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_force_utf8 = 1'b0;

    // sideband riding along with each byte request: a verdict typed into the script
    logic         row_typed = 1'b0;
    t_verdict_rec row_rec = '0;

    text_encoding_detector #(
        .WINDOW_BYTES(WINDOW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_verdict       (o_verdict),
        .o_bytes_examined(o_bytes_examined),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_force_utf8    (i_force_utf8)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bench-side detector state, mirrors what the block should hold
    // ------------------------------------------------------------------
    logic        force_bit = 1'b0;
    t_phase      det_phase = PH_LEAD;
    logic [7:0]  det_lead = 8'h00;
    logic [7:0]  det_second = 8'h00;
    int unsigned n_utf8 = 0;
    int unsigned n_euc = 0;
    int unsigned n_sjis = 0;
    int unsigned n_unk = 0;
    int unsigned n_bytes = 0;
    logic        verdict_out = 1'b0;   // verdict given, waiting for the last byte

    t_verdict_rec verdict_q[$];        // verdicts still owed by the block

    int unsigned errors = 0;
    int unsigned sent_count = 0;
    int unsigned checked_count = 0;
    int unsigned max_examined = 0;
    int unsigned seen_by_verdict[4] = '{0, 0, 0, 0};

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    logic        long_hold = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned cycles = 0;

    logic [7:0] file_bytes[$];

    function automatic logic in_span(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // tab, lf, cr and printable ascii up to and including tilde
    function automatic logic text_byte(input logic [7:0] b);
        return (b == B_TAB) || (b == B_LF) || (b == B_CR) || in_span(b, B_SPACE, B_TILDE);
    endfunction

    function automatic logic utf8_triple(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if (in_span(c, B_CONT_LO, B_CONT_HI)) begin
            if (a == B_U3_E0)
                ok = in_span(b, B_U3_E0_LO, B_CONT_HI);
            else if (a == B_U3_ED)
                ok = in_span(b, B_CONT_LO, B_U3_ED_HI);
            else if (in_span(a, B_U3_LO, B_U3_HI) || a == B_U3_EE || a == B_U3_EF)
                ok = in_span(b, B_CONT_LO, B_CONT_HI);
        end
        return ok;
    endfunction

    // euc pair first, then sjis pair, else nothing
    function automatic t_grp pair_kind(input logic [7:0] a, input logic [7:0] b);
        t_grp g;
        g = GRP_NONE;
        if (a == B_EUC_SS2 && in_span(b, B_EUC_LO, B_KANA_HI))
            g = GRP_EUC;
        else if (in_span(a, B_EUC_LO, B_EUC_HI) && in_span(b, B_EUC_LO, B_EUC_HI))
            g = GRP_EUC;
        else if ((in_span(a, B_SJ1_LO, B_SJ1_HI) || in_span(a, B_U3_E0, B_SJ1B_HI)) &&
                 (in_span(b, B_SJ2_LO, B_TILDE) || in_span(b, B_CONT_LO, B_SJ2_HI)))
            g = GRP_SJIS;
        return g;
    endfunction

    // a lead left on its own: half-width kana, or unknown
    task automatic count_lone(input logic [7:0] a);
        if (in_span(a, B_EUC_LO, B_KANA_HI))
            n_sjis++;
        else
            n_unk++;
    endtask

    task automatic restart_file();
        det_phase   = PH_LEAD;
        det_lead    = 8'h00;
        det_second  = 8'h00;
        n_utf8      = 0;
        n_euc       = 0;
        n_sjis      = 0;
        n_unk       = 0;
        n_bytes     = 0;
        verdict_out = 1'b0;
    endtask

    task automatic owe_verdict(input t_verdict v, input logic l);
        t_verdict_rec r;
        r.verdict  = v;
        r.examined = n_bytes[9:0];
        verdict_q.push_back(r);
        if (l)
            restart_file();
        else
            verdict_out = 1'b1;
    endtask

    // advance the detector by one accepted byte; may owe one verdict
    task automatic detect_byte(input logic [7:0] b, input logic l);
        logic   at_end;
        logic   nul_lead;
        t_grp   g;
        t_verdict v;
        if (verdict_out) begin
            // bytes after the verdict only matter when they close the file
            if (l)
                restart_file();
        end else begin
            n_bytes++;
            at_end = l || (n_bytes >= WINDOW);
            nul_lead = 1'b0;
            if (force_bit) begin
                owe_verdict(VERDICT_UTF8, l);
            end else begin
                case (det_phase)
                    PH_LEAD: begin
                        if (b == B_NUL)
                            nul_lead = 1'b1;
                        else if (!text_byte(b)) begin
                            if (at_end)
                                count_lone(b);
                            else begin
                                det_lead  = b;
                                det_phase = PH_SECOND;
                            end
                        end
                    end
                    PH_SECOND: begin
                        if (in_span(det_lead, B_U2_LO, B_U2_HI) &&
                            in_span(b, B_CONT_LO, B_CONT_HI)) begin
                            n_utf8++;
                            det_phase = PH_LEAD;
                        end else if (at_end) begin
                            count_lone(det_lead);
                            det_phase = PH_LEAD;
                        end else begin
                            det_second = b;
                            det_phase  = PH_THIRD;
                        end
                    end
                    default: begin
                        // third byte always closes the group
                        if (utf8_triple(det_lead, det_second, b))
                            n_utf8++;
                        else if (at_end)
                            count_lone(det_lead);
                        else begin
                            g = pair_kind(det_lead, det_second);
                            if (g == GRP_EUC)
                                n_euc++;
                            else if (g == GRP_SJIS)
                                n_sjis++;
                            else
                                count_lone(det_lead);
                        end
                        det_phase = PH_LEAD;
                    end
                endcase
                if (nul_lead)
                    owe_verdict(VERDICT_BINARY, l);
                else if (at_end) begin
                    if (n_unk * UNK_SCALE >= COUNT_SCALE * n_bytes)
                        v = VERDICT_BINARY;
                    else if (n_utf8 >= n_euc && n_utf8 >= n_sjis)
                        v = VERDICT_UTF8;
                    else if (n_euc >= n_sjis)
                        v = VERDICT_EUC;
                    else
                        v = VERDICT_SJIS;
                    owe_verdict(v, l);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: all handshakes sampled on the pre-edge values
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        int unsigned  depth;
        t_verdict_rec want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                force_bit = i_force_utf8;
            if (i_in_valid && o_in_ready) begin
                depth = verdict_q.size();
                detect_byte(i_data_byte, i_last_byte);
                // scripted rows carry their own verdict in place of the predicted one
                if (row_typed) begin
                    if (verdict_q.size() != depth)
                        void'(verdict_q.pop_back());
                    verdict_q.push_back(row_rec);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected verdict request: verdict %0d, bytes %0d",
                             $time, o_verdict, o_bytes_examined);
                end else begin
                    want = verdict_q.pop_front();
                    checked_count++;
                    seen_by_verdict[o_verdict]++;
                    if (o_bytes_examined > max_examined)
                        max_examined = o_bytes_examined;
                    if (o_verdict !== want.verdict) begin
                        errors++;
                        $display("%0t verdict mismatch: expected %0d, actual %0d",
                                 $time, want.verdict, o_verdict);
                    end
                    if (o_bytes_examined !== want.examined) begin
                        errors++;
                        $display("%0t bytes_examined mismatch: expected %0d, actual %0d",
                                 $time, want.examined, o_bytes_examined);
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a long counted hold-off on request
    always @(posedge i_clk) begin
        if (long_hold && hold_cnt < HOLD_LEN) begin
            hold_cnt    <= hold_cnt + 1;
            i_out_ready <= 1'b0;
        end else begin
            if (!long_hold)
                hold_cnt <= 0;
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("%0t watchdog expired with %0d verdicts outstanding",
                     $time, verdict_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one byte request; random gap before it, then hold until taken
    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input t_verdict_rec rec);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        row_typed   <= typed;
        row_rec     <= rec;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    // stop offering bytes and wait for every owed verdict
    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    // force bit is only written with the block idle
    task automatic write_force(input logic v);
        wait_results();
        repeat (LAT_GAP) @(posedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_force_utf8 <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_char(input t_ch_kind k);
        int unsigned r;
        r = $urandom_range(99);
        case (k)
            CH_ASCII: begin
                if (r < 5)
                    file_bytes.push_back(B_TAB);
                else if (r < 10)
                    file_bytes.push_back(B_LF);
                else if (r < 13)
                    file_bytes.push_back(B_CR);
                else
                    file_bytes.push_back(8'($urandom_range(B_TILDE, B_SPACE)));
            end
            CH_U2: begin
                file_bytes.push_back(8'($urandom_range(B_U2_HI, B_U2_LO)));
                file_bytes.push_back(8'($urandom_range(B_CONT_HI, B_CONT_LO)));
            end
            CH_U3: begin
                if (r < 20) begin
                    file_bytes.push_back(B_U3_E0);
                    file_bytes.push_back(8'($urandom_range(B_CONT_HI, B_U3_E0_LO)));
                end else if (r < 40) begin
                    file_bytes.push_back(B_U3_ED);
                    file_bytes.push_back(8'($urandom_range(B_U3_ED_HI, B_CONT_LO)));
                end else begin
                    if (r < 85)
                        file_bytes.push_back(8'($urandom_range(B_U3_HI, B_U3_LO)));
                    else
                        file_bytes.push_back(8'($urandom_range(B_U3_EF, B_U3_EE)));
                    file_bytes.push_back(8'($urandom_range(B_CONT_HI, B_CONT_LO)));
                end
                file_bytes.push_back(8'($urandom_range(B_CONT_HI, B_CONT_LO)));
            end
            CH_EUC: begin
                file_bytes.push_back(8'($urandom_range(B_EUC_HI, B_EUC_LO)));
                file_bytes.push_back(8'($urandom_range(B_EUC_HI, B_EUC_LO)));
            end
            CH_SS2: begin
                file_bytes.push_back(B_EUC_SS2);
                file_bytes.push_back(8'($urandom_range(B_KANA_HI, B_EUC_LO)));
            end
            CH_SJIS: begin
                if (r < 60)
                    file_bytes.push_back(8'($urandom_range(B_SJ1_HI, B_SJ1_LO)));
                else
                    file_bytes.push_back(8'($urandom_range(B_SJ1B_HI, B_U3_E0)));
                if ($urandom_range(1))
                    file_bytes.push_back(8'($urandom_range(B_TILDE, B_SJ2_LO)));
                else
                    file_bytes.push_back(8'($urandom_range(B_SJ2_HI, B_CONT_LO)));
            end
            CH_KANA: file_bytes.push_back(8'($urandom_range(B_KANA_HI, B_EUC_LO)));
            default: file_bytes.push_back(8'($urandom_range(255)));
        endcase
    endtask

    // mostly well-formed text of one flavor, with ascii runs and some noise
    task automatic make_file(input t_flavor fl, input int unsigned len);
        int unsigned r;
        t_ch_kind    k;
        file_bytes.delete();
        while (file_bytes.size() < len) begin
            r = $urandom_range(99);
            if (fl == FL_NOISE || (r >= 45 && r < 50))
                k = CH_RAW;
            else if (r < 45)
                k = CH_ASCII;
            else if (fl == FL_UTF8)
                k = (r < 80) ? CH_U3 : CH_U2;
            else if (fl == FL_EUC)
                k = (r < 85) ? CH_EUC : CH_SS2;
            else if (fl == FL_SJIS)
                k = (r < 75) ? CH_SJIS : CH_KANA;
            else
                k = t_ch_kind'($urandom_range(CH_RAW, CH_U2));
            add_char(k);
        end
        // cutting at the length often leaves a group broken at the end
        while (file_bytes.size() > len)
            void'(file_bytes.pop_back());
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, '0);
    endtask

    task automatic random_file();
        int unsigned r;
        int unsigned len;
        t_flavor     fl;
        r = $urandom_range(99);
        if (r < 28)
            fl = FL_UTF8;
        else if (r < 56)
            fl = FL_EUC;
        else if (r < 84)
            fl = FL_SJIS;
        else if (r < 94)
            fl = FL_MIXED;
        else
            fl = FL_NOISE;
        // short files mostly, now and then one near the window length that may run past it
        r = $urandom_range(99);
        if (r < 3)
            len = $urandom_range(WINDOW + 8, WINDOW - 8);
        else if (r < 20)
            len = $urandom_range(80, 17);
        else
            len = $urandom_range(16, 1);
        make_file(fl, len);
        send_file();
    endtask

    task automatic run_phase(input int unsigned src, input int unsigned sink,
                             input int unsigned n_req);
        int unsigned start;
        src_idle_pct   = src;
        sink_stall_pct = sink;
        start = sent_count;
        while (sent_count - start < n_req)
            random_file();
        wait_results();
    endtask

    // scripted files; typed verdicts only where they are obvious
    t_row script [31] = '{
        '{ROW_BYTE,  8'h00, 1'b1, 1'b1, '{VERDICT_BINARY, 10'd1}},  // nul at lead
        '{ROW_BYTE,  8'h7E, 1'b1, 1'b1, '{VERDICT_UTF8,   10'd1}},  // tilde is text
        '{ROW_BYTE,  8'hFF, 1'b1, 1'b1, '{VERDICT_BINARY, 10'd1}},  // lone unknown lead
        '{ROW_BYTE,  8'hA1, 1'b1, 1'b1, '{VERDICT_SJIS,   10'd1}},  // half-width kana
        '{ROW_BYTE,  8'hC3, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'hA9, 1'b1, 1'b1, '{VERDICT_UTF8,   10'd2}},  // two-byte utf-8
        '{ROW_BYTE,  8'hC3, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h00, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},  // nul inside a group
        '{ROW_BYTE,  8'h09, 1'b1, 1'b1, '{VERDICT_SJIS,   10'd3}},  // lead left as kana
        '{ROW_BYTE,  8'hA4, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'hA2, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h20, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},  // third byte eaten
        '{ROW_BYTE,  8'h0A, 1'b1, 1'b1, '{VERDICT_EUC,    10'd4}},
        '{ROW_BYTE,  8'h82, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h40, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h7E, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h0D, 1'b1, 1'b1, '{VERDICT_SJIS,   10'd4}},
        '{ROW_BYTE,  8'hE0, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'hA0, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'hBF, 1'b1, 1'b1, '{VERDICT_UTF8,   10'd3}},  // three-byte utf-8
        '{ROW_BYTE,  8'hE3, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h81, 1'b1, 1'b1, '{VERDICT_BINARY, 10'd2}},  // group cut short
        '{ROW_FORCE, 8'h01, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h80, 1'b0, 1'b1, '{VERDICT_UTF8,   10'd1}},  // forced verdict
        '{ROW_BYTE,  8'h00, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},  // ignored
        '{ROW_BYTE,  8'h41, 1'b1, 1'b0, '{VERDICT_UTF8,   10'd0}},  // ignored, rearms
        '{ROW_FORCE, 8'h00, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h8E, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},  // euc single shift
        '{ROW_BYTE,  8'hB1, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'h20, 1'b0, 1'b0, '{VERDICT_UTF8,   10'd0}},
        '{ROW_BYTE,  8'hED, 1'b1, 1'b0, '{VERDICT_UTF8,   10'd0}}
    };

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // scripted part, no idling
        foreach (script[i]) begin
            if (script[i].kind == ROW_FORCE)
                write_force(script[i].data[0]);
            else
                send_byte(script[i].data, script[i].last, script[i].typed, script[i].rec);
        end
        wait_results();

        // one file that fills the window before its last byte
        make_file(FL_UTF8, WINDOW + 6);
        send_file();
        wait_results();

        run_phase(0, 0, 180);

        // receiver holds off while one-byte files keep coming, so the block backs up
        long_hold <= 1'b1;
        repeat (40)
            send_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0);
        long_hold <= 1'b0;
        wait_results();

        write_force(1'b1);
        run_phase(0, 0, 50);
        write_force(1'b0);

        run_phase(51, 0, 180);
        run_phase(0, 51, 180);

        write_force(1'b1);
        run_phase(30, 30, 50);
        write_force(1'b0);

        run_phase(30, 30, 180);

        repeat (LAT_GAP) @(posedge i_clk);

        $display("covered %0d byte requests and %0d verdicts, longest file %0d bytes",
                 sent_count, checked_count, max_examined);
        $display("verdicts utf8 %0d, euc %0d, sjis %0d, binary %0d; force bit on and off",
                 seen_by_verdict[VERDICT_UTF8], seen_by_verdict[VERDICT_EUC],
                 seen_by_verdict[VERDICT_SJIS], seen_by_verdict[VERDICT_BINARY]);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ted_pkg.sv
rtl/core/text_encoding_detector.sv
sim/text_encoding_detector_tb.sv
